// ===== sv/obdpr_pkg.sv =====
// obdpr_pkg: request and reply types, register map, format codes and constants
// for the mode 1 PID responder; used by every file of the block
// no dependencies
package obdpr_pkg;

  localparam int ADDR_W = 5;
  localparam int XW = 48;
  localparam int FORMAT_TABLE_ENTRIES_DEF = 65;

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_REQ_STD = 3'd0;
  localparam logic [2:0] REG_RSP_STD = 3'd1;
  localparam logic [2:0] REG_REQ_EXT = 3'd2;
  localparam logic [2:0] REG_RSP_EXT = 3'd3;
  localparam logic [2:0] REG_START_SEC = 3'd4;
  localparam logic [2:0] REG_SAT_EN = 3'd5;

  localparam logic [28:0] RST_REQ_STD = 29'h000007DF;
  localparam logic [28:0] RST_RSP_STD = 29'h000007E8;
  localparam logic [28:0] RST_REQ_EXT = 29'h18DB33F1;
  localparam logic [28:0] RST_RSP_EXT = 29'h18DAF110;

  localparam logic [7:0] MODE_CURRENT = 8'h01;
  localparam logic [7:0] MODE_REPLY = 8'h41;
  localparam logic [7:0] LEN_BYTE = 8'h06;
  localparam logic [7:0] PAD_BYTE = 8'h55;
  localparam logic [7:0] PAD_STATUS = 8'hFF;

  localparam logic [7:0] PID_SUPPORT_00 = 8'h00;
  localparam logic [7:0] PID_STATUS = 8'h01;
  localparam logic [7:0] PID_RPM = 8'h0C;
  localparam logic [7:0] PID_MAF = 8'h10;
  localparam logic [7:0] PID_RUN_TIME = 8'h1F;
  localparam logic [7:0] PID_SUPPORT_20 = 8'h20;
  localparam logic [7:0] PID_SUPPORT_40 = 8'h40;

  localparam logic [31:0] BITMAP_00 = 32'h183B8002;
  localparam logic [31:0] BITMAP_20 = 32'h08028000;
  localparam logic [31:0] BITMAP_40 = 32'h00000000;

  localparam logic signed [XW-1:0] RPM_SCALE = 48'sd70;
  localparam logic signed [XW-1:0] MAF_SCALE = 48'sd3;
  localparam logic signed [XW-1:0] PCT_SCALE = 48'sd51;
  localparam logic signed [XW-1:0] CENT_SCALE = 48'sd25;
  localparam logic signed [XW-1:0] TRIM_OFFSET = 48'sd16384;
  localparam logic signed [XW-1:0] VOLT_OFFSET = 48'sd25600;
  localparam logic signed [XW-1:0] RPM_FLOOR = 48'sd256;
  localparam logic signed [XW-1:0] QUARTER_MAX = 48'sd4194240;
  localparam logic signed [XW-1:0] CENT_MAX = 48'sd167769;
  localparam logic [9:0] RPM_IDLE = 10'd500;
  localparam logic [7:0] TEMP_OFFSET = 8'd40;

  // 2^20 = d*K + 1 for d in 3, 5, 25
  localparam logic [7:0] K3_LO = 8'((2**20 - 1) / 3);
  localparam logic [7:0] K5_LO = 8'((2**20 - 1) / 5);
  localparam logic [7:0] K25_LO = 8'((2**20 - 1) / 25);
  // reciprocals, ceil(2^26/d)
  localparam int RECIP_SH = 26;
  localparam logic [24:0] M3 = 25'((2**26 + 2) / 3);
  localparam logic [24:0] M5 = 25'((2**26 + 4) / 5);
  localparam logic [24:0] M25 = 25'((2**26 + 24) / 25);

  typedef enum logic [3:0] {
    FMT_NONE = 4'd0,
    FMT_BYTE = 4'd1,
    FMT_PCT = 4'd2,
    FMT_QUARTER = 4'd3,
    FMT_TEMP = 4'd4,
    FMT_WORD = 4'd5,
    FMT_CENT = 4'd6,
    FMT_THIRD = 4'd7,
    FMT_TRIM = 4'd8,
    FMT_VOLT = 4'd9,
    FMT_LONG = 4'd10
  } fmt_t;

  typedef enum logic [1:0] {
    DIV_1,
    DIV_3,
    DIV_5,
    DIV_25
  } div_t;

  typedef struct packed {
    logic [28:0] msg_id;
    logic [7:0] service_mode;
    logic [7:0] pid_code;
    logic signed [39:0] pid_value;
    logic [31:0] now_seconds;
  } req_t;

  typedef struct packed {
    logic [28:0] reply_id;
    logic extended_frame;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
  } rsp_t;

  typedef struct packed {
    logic [28:0] request_id_std;
    logic [28:0] response_id_std;
    logic [28:0] request_id_ext;
    logic [28:0] response_id_ext;
    logic [31:0] start_seconds;
    logic saturate_enable;
  } cfg_t;

  typedef struct packed {
    logic [28:0] reply_id;
    logic extended_frame;
    logic [7:0] pid_code;
    logic [7:0] pad;
  } hdr_t;

  typedef struct packed {
    hdr_t hdr;
    logic direct;
    logic [31:0] data;
    fmt_t fmt;
  } frame_t;

  typedef struct packed {
    frame_t frame;
    logic rpm;
    logic [3:0] jitter;
    logic signed [XW-1:0] x;
  } dec_t;

  typedef struct packed {
    frame_t frame;
    logic sat;
    logic neg;
    div_t dsel;
    logic [31:0] n32;
    logic [7:0] q8;
  } quot_t;

  function automatic fmt_t fmt_lookup(input logic [7:0] pid);
    fmt_t f;
    unique case (pid)
      8'd0, 8'd1, 8'd3, 8'd18, 8'd28, 8'd32, 8'd64: f = FMT_LONG;
      8'd4, 8'd17, 8'd47: f = FMT_PCT;
      8'd5, 8'd15: f = FMT_TEMP;
      8'd6, 8'd7, 8'd8, 8'd9: f = FMT_VOLT;
      8'd10: f = FMT_THIRD;
      8'd11, 8'd13, 8'd51: f = FMT_BYTE;
      8'd12, 8'd31: f = FMT_QUARTER;
      8'd14: f = FMT_TRIM;
      8'd16: f = FMT_CENT;
      8'd33: f = FMT_WORD;
      default: f = FMT_NONE;
    endcase
    return f;
  endfunction

endpackage

// ===== sv/obd2_mode1_pid_responder_core.sv =====
// obd2_mode1_pid_responder_core: mode 1 PID reply encoder, register port,
// request register and reply register
// depends on obdpr_pkg, obdpr_decode, obdpr_scale, obdpr_fold
//
// channel    direction  handshake                     payload
// request    in         start, taken when busy low    req (req_t)
// reply      out        done, one-cycle strobe        rsp (rsp_t)
// registers  in/out     psel/penable/pwrite, pready   paddr, pwdata, prdata
//
// one request per cycle; busy is never raised
// a reply leaves through the request register, decode, five arithmetic
// stages and the reply register
// requests that do not match produce no reply and leave no gap
// synchronous reset clears the valid pipeline and sets the registers to their reset values; no sweep
// the receiver cannot stall: done is a strobe and is never held off
module obd2_mode1_pid_responder_core import obdpr_pkg::*; #(
  parameter int FORMAT_TABLE_ENTRIES = FORMAT_TABLE_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  req_t              req,
  output logic              done,
  output rsp_t              rsp,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int LATENCY = 8;

  cfg_t cfg;
  logic in_valid;
  req_t in_req;
  logic dec_valid;
  dec_t dec;
  logic quot_valid;
  quot_t quot;
  logic [31:0] data;

  assign busy = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.request_id_std <= RST_REQ_STD;
      cfg.response_id_std <= RST_RSP_STD;
      cfg.request_id_ext <= RST_REQ_EXT;
      cfg.response_id_ext <= RST_RSP_EXT;
      cfg.start_seconds <= '0;
      cfg.saturate_enable <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[ADDR_W-1:2])
        REG_REQ_STD: cfg.request_id_std <= pwdata[28:0];
        REG_RSP_STD: cfg.response_id_std <= pwdata[28:0];
        REG_REQ_EXT: cfg.request_id_ext <= pwdata[28:0];
        REG_RSP_EXT: cfg.response_id_ext <= pwdata[28:0];
        REG_START_SEC: cfg.start_seconds <= pwdata;
        REG_SAT_EN: cfg.saturate_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_REQ_STD: prdata = {3'd0, cfg.request_id_std};
      REG_RSP_STD: prdata = {3'd0, cfg.response_id_std};
      REG_REQ_EXT: prdata = {3'd0, cfg.request_id_ext};
      REG_RSP_EXT: prdata = {3'd0, cfg.response_id_ext};
      REG_START_SEC: prdata = cfg.start_seconds;
      REG_SAT_EN: prdata = {31'd0, cfg.saturate_enable};
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
    if (start && !busy) begin
      in_req <= req;
    end
  end

  obdpr_decode #(
    .FORMAT_TABLE_ENTRIES(FORMAT_TABLE_ENTRIES)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_req    (in_req),
    .cfg       (cfg),
    .dec_valid (dec_valid),
    .dec       (dec)
  );

  obdpr_scale u_scale (
    .clk             (clk),
    .rst             (rst),
    .saturate_enable (cfg.saturate_enable),
    .dec_valid       (dec_valid),
    .dec             (dec),
    .quot_valid      (quot_valid),
    .quot            (quot)
  );

  obdpr_fold u_fold (
    .quot (quot),
    .data (data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= quot_valid;
    end
    rsp.reply_id <= quot.frame.hdr.reply_id;
    rsp.extended_frame <= quot.frame.hdr.extended_frame;
    rsp.byte0 <= LEN_BYTE;
    rsp.byte1 <= MODE_REPLY;
    rsp.byte2 <= quot.frame.hdr.pid_code;
    rsp.byte3 <= data[31:24];
    rsp.byte4 <= data[23:16];
    rsp.byte5 <= data[15:8];
    rsp.byte6 <= data[7:0];
    rsp.byte7 <= quot.frame.hdr.pad;
  end

  a_reply_has_request: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("reply without a request taken");

  a_reply_mode_one: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(req.service_mode, LATENCY) == MODE_CURRENT))
    else $error("reply to a request that was not mode 1");

  a_reply_echo_pid: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.byte2 == $past(req.pid_code, LATENCY)))
    else $error("reply PID does not match its request");

endmodule

// ===== sv/obdpr_decode.sv =====
// obdpr_decode: identifier and mode match, PID dispatch and first scaling
// depends on obdpr_pkg
module obdpr_decode import obdpr_pkg::*; #(
  parameter int FORMAT_TABLE_ENTRIES = FORMAT_TABLE_ENTRIES_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  req_t   in_req,
  input  cfg_t   cfg,
  output logic   dec_valid,
  output dec_t   dec
);

  localparam logic [8:0] ENTRIES = 9'(FORMAT_TABLE_ENTRIES);

  logic hit_std;
  logic hit_ext;
  logic known;
  logic keep;
  logic signed [XW-1:0] v48;
  logic [31:0] run_time;
  dec_t dec_next;

  always_comb begin
    hit_std = (in_req.msg_id == cfg.request_id_std);
    hit_ext = (in_req.msg_id == cfg.request_id_ext);
    v48 = XW'(in_req.pid_value);
    run_time = in_req.now_seconds - cfg.start_seconds;

    dec_next.frame.hdr.reply_id = hit_std ? cfg.response_id_std : cfg.response_id_ext;
    dec_next.frame.hdr.extended_frame = !hit_std;
    dec_next.frame.hdr.pid_code = in_req.pid_code;
    dec_next.frame.hdr.pad = PAD_BYTE;
    dec_next.frame.direct = 1'b0;
    dec_next.frame.data = '0;
    dec_next.frame.fmt = fmt_lookup(in_req.pid_code);
    dec_next.rpm = 1'b0;
    dec_next.jitter = in_req.now_seconds[3:0];
    dec_next.x = v48;
    known = 1'b1;

    unique case (in_req.pid_code)
      PID_SUPPORT_00: begin
        dec_next.frame.direct = 1'b1;
        dec_next.frame.data = BITMAP_00;
      end
      PID_STATUS: begin
        dec_next.frame.direct = 1'b1;
        dec_next.frame.hdr.pad = PAD_STATUS;
      end
      PID_SUPPORT_20: begin
        dec_next.frame.direct = 1'b1;
        dec_next.frame.data = BITMAP_20;
      end
      PID_SUPPORT_40: begin
        dec_next.frame.direct = 1'b1;
        dec_next.frame.data = BITMAP_40;
      end
      PID_RPM: begin
        dec_next.frame.fmt = FMT_QUARTER;
        dec_next.rpm = 1'b1;
        dec_next.x = v48 * RPM_SCALE
                   + signed'({36'd0, in_req.now_seconds[3:0], 8'd0});
      end
      PID_MAF: begin
        dec_next.frame.fmt = FMT_CENT;
        dec_next.x = v48 * MAF_SCALE;
      end
      PID_RUN_TIME: begin
        dec_next.frame.direct = 1'b1;
        dec_next.frame.data = {run_time[15:0], 16'd0};
      end
      default: begin
        known = 1'b0;
      end
    endcase

    keep = (hit_std || hit_ext) && (in_req.service_mode == MODE_CURRENT)
         && (known || ({1'b0, in_req.pid_code} < ENTRIES));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dec_valid <= 1'b0;
    end else begin
      dec_valid <= in_valid && keep;
    end
    if (in_valid) begin
      dec <= dec_next;
    end
  end

endmodule

// ===== sv/obdpr_scale.sv =====
// obdpr_scale: five-stage pipeline that applies the format formulas,
// truncating divides by powers of two and by 3, 5 and 25
// depends on obdpr_pkg
module obdpr_scale import obdpr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   saturate_enable,
  input  logic   dec_valid,
  input  dec_t   dec,
  output logic   quot_valid,
  output quot_t  quot
);

  // idle clamp
  logic v3;
  frame_t f3;
  logic signed [XW-1:0] x3;
  logic signed [XW-1:0] x3_next;

  // numerator
  logic v4;
  frame_t f4;
  logic sat4;
  logic signed [XW-1:0] n4;
  logic [3:0] sh4;
  div_t d4;
  logic sat4_next;
  logic signed [XW-1:0] n4_next;
  logic [3:0] sh4_next;
  div_t d4_next;

  // magnitude and shift
  logic v5;
  frame_t f5;
  logic sat5;
  logic neg5;
  logic [36:0] n5;
  div_t d5;
  logic [XW-1:0] mag;
  logic [XW-1:0] shifted;

  // chunk sum
  logic v6;
  frame_t f6;
  logic sat6;
  logic neg6;
  logic [20:0] s6;
  logic [7:0] hi6;
  logic [31:0] n32_6;
  div_t d6;
  logic [7:0] k_lo;
  logic [15:0] hi_prod;

  // reciprocal multiply
  logic [24:0] recip;
  logic [45:0] prod;

  always_comb begin
    x3_next = dec.x;
    if (dec.rpm && (dec.x < RPM_FLOOR)) begin
      x3_next = signed'({30'd0, RPM_IDLE + 10'(dec.jitter), 8'd0});
    end
  end

  always_comb begin
    sat4_next = saturate_enable
              && (((f3.fmt == FMT_QUARTER) && (x3 > QUARTER_MAX))
               || ((f3.fmt == FMT_CENT) && (x3 > CENT_MAX)));
    n4_next = x3;
    sh4_next = 4'd8;
    d4_next = DIV_1;
    unique case (f3.fmt)
      FMT_PCT: begin
        n4_next = x3 * PCT_SCALE;
        sh4_next = 4'd10;
        d4_next = DIV_5;
      end
      FMT_QUARTER: sh4_next = 4'd6;
      FMT_CENT: begin
        n4_next = x3 * CENT_SCALE;
        sh4_next = 4'd6;
      end
      FMT_THIRD: d4_next = DIV_3;
      FMT_TRIM: begin
        n4_next = x3 + TRIM_OFFSET;
        sh4_next = 4'd7;
      end
      FMT_VOLT: begin
        n4_next = x3 + VOLT_OFFSET;
        sh4_next = 4'd3;
        d4_next = DIV_25;
      end
      default: begin
        sh4_next = 4'd8;
      end
    endcase
  end

  assign mag = n4[XW-1] ? (XW'(0) - $unsigned(n4)) : $unsigned(n4);
  assign shifted = mag >> sh4;

  always_comb begin
    unique case (d5)
      DIV_3: k_lo = K3_LO;
      DIV_5: k_lo = K5_LO;
      DIV_25: k_lo = K25_LO;
      default: k_lo = 8'd0;
    endcase
    hi_prod = n5[27:20] * k_lo;
  end

  always_comb begin
    unique case (d6)
      DIV_3: recip = M3;
      DIV_5: recip = M5;
      DIV_25: recip = M25;
      default: recip = 25'd0;
    endcase
    prod = 46'(s6) * 46'(recip);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      quot_valid <= 1'b0;
    end else begin
      v3 <= dec_valid;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      quot_valid <= v6;
    end

    f3 <= dec.frame;
    x3 <= x3_next;

    f4 <= f3;
    sat4 <= sat4_next;
    n4 <= n4_next;
    sh4 <= sh4_next;
    d4 <= d4_next;

    f5 <= f4;
    sat5 <= sat4;
    neg5 <= n4[XW-1];
    n5 <= shifted[36:0];
    d5 <= d4;

    f6 <= f5;
    sat6 <= sat5;
    neg6 <= neg5;
    s6 <= 21'(n5[36:20]) + 21'(n5[19:0]);
    hi6 <= hi_prod[7:0];
    n32_6 <= n5[31:0];
    d6 <= d5;

    quot.frame <= f6;
    quot.sat <= sat6;
    quot.neg <= neg6;
    quot.dsel <= d6;
    quot.n32 <= n32_6;
    quot.q8 <= hi6 + prod[RECIP_SH+7:RECIP_SH];
  end

endmodule

// ===== sv/obdpr_pkg_unused_guard.sv =====
// obdpr_fold: applies sign, temperature offset and saturation and places
// the data bytes of one reply, or passes the direct data through
// depends on obdpr_pkg
module obdpr_fold import obdpr_pkg::*; (
  input  quot_t        quot,
  output logic [31:0]  data
);

  logic [31:0] mag;
  logic [31:0] sval;

  always_comb begin
    mag = (quot.dsel == DIV_1) ? quot.n32 : {24'd0, quot.q8};
    sval = quot.neg ? (32'd0 - mag) : mag;
    data = '0;
    unique case (quot.frame.fmt)
      FMT_BYTE, FMT_PCT, FMT_THIRD, FMT_TRIM, FMT_VOLT: data[31:24] = sval[7:0];
      FMT_TEMP: data[31:24] = sval[7:0] + TEMP_OFFSET;
      FMT_QUARTER, FMT_WORD, FMT_CENT: data[31:16] = sval[15:0];
      FMT_LONG: data = sval;
      default: data = '0;
    endcase
    if (quot.sat) begin
      data[31:16] = 16'hFFFF;
    end
    if (quot.frame.direct) begin
      data = quot.frame.data;
    end
  end

endmodule
